FILE: hdl/i2cdbw_pkg.sv
// Package for the I2C display byte writer: item types, tick phase codes and
// byte constants. No dependencies.
`default_nettype none

package i2cdbw_pkg;

  typedef struct packed {
    logic       start_req;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic addr_nack;
  } out_item_t;

  typedef logic [4:0] phase_t;

  // tick positions: start 1..5, bit 6..10, ack 11..16, stop 17..20
  localparam phase_t PH_IDLE  = 5'd0;
  localparam phase_t PH_START = 5'd1;
  localparam phase_t PH_BIT   = 5'd6;
  localparam phase_t PH_ACK   = 5'd11;
  localparam phase_t PH_STOP  = 5'd17;
  localparam phase_t PH_LAST  = 5'd20;

  localparam logic [1:0] BYTE_ADDR  = 2'd0;
  localparam logic [1:0] BYTE_CTRL  = 2'd1;
  localparam logic [1:0] BYTE_PAY   = 2'd2;
  localparam logic [1:0] BYTE_ABORT = 2'd3;

  localparam logic [7:0] ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;

endpackage

`default_nettype wire

FILE: hdl/i2cdbw_seq.sv
// Tick sequencer of the I2C display byte writer: transfer state registers
// and the per-tick next-state and line logic. Uses i2cdbw_pkg.
`default_nettype none

module i2cdbw_seq (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   step,
  input  i2cdbw_pkg::in_item_t  item,
  input  wire  [7:0]            device_address,
  output i2cdbw_pkg::out_item_t result
);

  i2cdbw_pkg::phase_t phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [1:0] byte_index, byte_index_next;
  logic [7:0] held_payload, held_payload_next;
  logic       held_is_data, held_is_data_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       sda_released, sda_released_next;

  logic [4:0] t;
  logic [7:0] cur_byte;
  logic       busy, done, nack;

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    held_payload_next = held_payload;
    held_is_data_next = held_is_data;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    sda_released_next = sda_released;
    busy = 1'b0;
    done = 1'b0;
    nack = 1'b0;
    t    = 5'd0;

    if (phase_next > i2cdbw_pkg::PH_LAST) begin
      phase_next = i2cdbw_pkg::PH_IDLE;
    end

    if (phase_next == i2cdbw_pkg::PH_IDLE && item.start_req) begin
      held_is_data_next = item.is_data;
      held_payload_next = item.payload;
      byte_index_next   = i2cdbw_pkg::BYTE_ADDR;
      bit_index_next    = 3'd0;
      phase_next        = i2cdbw_pkg::PH_START;
    end

    case (byte_index_next)
      i2cdbw_pkg::BYTE_ADDR: cur_byte = device_address;
      i2cdbw_pkg::BYTE_CTRL:
        cur_byte = held_is_data_next ? i2cdbw_pkg::CTRL_DATA : i2cdbw_pkg::CTRL_CMD;
      default:               cur_byte = held_payload_next;
    endcase

    if (phase_next != i2cdbw_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (phase_next < i2cdbw_pkg::PH_BIT) begin
        t = phase_next - i2cdbw_pkg::PH_START;
        if (t == 5'd2) sda_level_next = 1'b0;
        if (t == 5'd4) scl_level_next = 1'b0;
        phase_next = phase_next + 5'd1;
      end else if (phase_next < i2cdbw_pkg::PH_ACK) begin
        t = phase_next - i2cdbw_pkg::PH_BIT;
        if (t == 5'd1) sda_level_next = cur_byte[3'd7 - bit_index_next];
        if (t == 5'd2) scl_level_next = 1'b1;
        if (t == 5'd3) scl_level_next = 1'b0;
        if (t == 5'd4) begin
          sda_level_next = 1'b0;
          if (bit_index_next == 3'd7) begin
            bit_index_next = 3'd0;
            phase_next     = i2cdbw_pkg::PH_ACK;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = i2cdbw_pkg::PH_BIT;
          end
        end else begin
          phase_next = phase_next + 5'd1;
        end
      end else if (phase_next < i2cdbw_pkg::PH_STOP) begin
        t = phase_next - i2cdbw_pkg::PH_ACK;
        if (t == 5'd1) sda_released_next = 1'b1;
        if (t == 5'd2) scl_level_next = 1'b1;
        // only an address NACK aborts
        if (t == 5'd3 && byte_index_next == i2cdbw_pkg::BYTE_ADDR && item.sda_in) begin
          byte_index_next = i2cdbw_pkg::BYTE_ABORT;
        end
        if (t == 5'd4) scl_level_next = 1'b0;
        if (t == 5'd5) begin
          sda_released_next = 1'b0;
          if (byte_index_next >= i2cdbw_pkg::BYTE_PAY) begin
            phase_next = i2cdbw_pkg::PH_STOP;
          end else begin
            byte_index_next = byte_index_next + 2'd1;
            phase_next      = i2cdbw_pkg::PH_BIT;
          end
        end else begin
          phase_next = phase_next + 5'd1;
        end
      end else begin
        t = phase_next - i2cdbw_pkg::PH_STOP;
        if (t == 5'd1) scl_level_next = 1'b1;
        if (t == 5'd2) sda_level_next = 1'b1;
        if (t == 5'd3) begin
          done       = 1'b1;
          nack       = (byte_index_next == i2cdbw_pkg::BYTE_ABORT);
          phase_next = i2cdbw_pkg::PH_IDLE;
        end else begin
          phase_next = phase_next + 5'd1;
        end
      end
    end

    result.scl       = scl_level_next;
    result.sda_out   = sda_released_next ? 1'b0 : sda_level_next;
    result.sda_drive = ~sda_released_next;
    result.busy_res  = busy;
    result.done_res  = done;
    result.addr_nack = nack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cdbw_pkg::PH_IDLE;
      bit_index    <= 3'd0;
      byte_index   <= i2cdbw_pkg::BYTE_ADDR;
      held_payload <= 8'd0;
      held_is_data <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      sda_released <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      held_payload <= held_payload_next;
      held_is_data <= held_is_data_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      sda_released <= sda_released_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2c_display_byte_writer.sv
// Top level of the I2C display byte writer: handshakes, address register and
// result register around the tick sequencer. Uses i2cdbw_pkg, i2cdbw_seq.
`default_nettype none

// Bit-banged I2C write master. Each input item is one bus tick and yields
// exactly one result item with the line levels and status for that tick. An
// idle tick with start_req set begins a transfer: start (5 ticks), then the
// address byte (device_address), control byte and payload byte (40 bit ticks
// plus 6 ack ticks each), then stop (4 ticks); 147 ticks in all, 55 if the
// address is not acknowledged. Bus timing is set entirely by the rate at
// which items are fed. The block takes one item per clock cycle; its result
// appears in the output register on the next cycle, and a new item is taken
// whenever that register is empty or being read in the same cycle.
// device_address may be written at any time through the cfg channel, which
// is always ready.
module i2c_display_byte_writer (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  i2cdbw_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output i2cdbw_pkg::out_item_t out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [7:0]            cfg_data
);

  logic [7:0]            device_address;
  logic                  step;
  i2cdbw_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid | out_ready;
  assign step      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cdbw_pkg::ADDR_RESET;
    end else if (cfg_valid) begin
      device_address <= cfg_data;
    end
  end

  i2cdbw_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (in_data),
    .device_address (device_address),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: test/i2c_tick_checker.sv
// Checker for the I2C display byte writer: watches the in, out and cfg
// channels, predicts the line levels and status of every bus tick and compares them.
// Depends on i2cdbw_pkg.
`timescale 1ns / 100ps

module i2c_tick_checker (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   in_ready,
  input  i2cdbw_pkg::in_item_t  in_data,
  input  wire                   out_valid,
  input  wire                   out_ready,
  input  i2cdbw_pkg::out_item_t out_data,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire  [7:0]            cfg_data,
  output int                    fail_count,
  output int                    levels_pending
);

  // predicted bus state
  i2cdbw_pkg::phase_t ph;
  logic [2:0] bit_no;
  logic [1:0] byte_no;
  logic [7:0] pay_hold;
  logic       data_hold;
  logic       scl_q;
  logic       sda_q;
  logic       rel_q;
  logic [7:0] dev_addr;

  i2cdbw_pkg::out_item_t levels_due[$];
  int         errors = 0;

  function automatic logic [7:0] byte_on_wire();
    case (byte_no)
      i2cdbw_pkg::BYTE_ADDR: return dev_addr;
      i2cdbw_pkg::BYTE_CTRL:
        return data_hold ? i2cdbw_pkg::CTRL_DATA : i2cdbw_pkg::CTRL_CMD;
      default:               return pay_hold;
    endcase
  endfunction

  // advances the predicted master by one tick and returns the line levels and status
  function automatic i2cdbw_pkg::out_item_t bus_tick(i2cdbw_pkg::in_item_t it);
    i2cdbw_pkg::out_item_t r;
    logic [4:0] t;
    logic [7:0] w;
    logic       busy;
    logic       done;
    logic       nack;
    busy = 1'b0;
    done = 1'b0;
    nack = 1'b0;
    if (ph > i2cdbw_pkg::PH_LAST) ph = i2cdbw_pkg::PH_IDLE;
    if (ph == i2cdbw_pkg::PH_IDLE && it.start_req) begin
      data_hold = it.is_data;
      pay_hold  = it.payload;
      byte_no   = i2cdbw_pkg::BYTE_ADDR;
      bit_no    = 3'd0;
      ph        = i2cdbw_pkg::PH_START;
    end
    if (ph != i2cdbw_pkg::PH_IDLE) begin
      busy = 1'b1;
      if (ph < i2cdbw_pkg::PH_BIT) begin
        t = ph - i2cdbw_pkg::PH_START;
        if (t == 5'd2) sda_q = 1'b0;
        if (t == 5'd4) scl_q = 1'b0;
        ph = ph + 5'd1;
      end else if (ph < i2cdbw_pkg::PH_ACK) begin
        t = ph - i2cdbw_pkg::PH_BIT;
        if (t == 5'd1) begin
          w     = byte_on_wire();
          sda_q = w[3'd7 - bit_no];
        end
        if (t == 5'd2) scl_q = 1'b1;
        if (t == 5'd3) scl_q = 1'b0;
        if (t == 5'd4) begin
          sda_q = 1'b0;
          if (bit_no == 3'd7) begin
            bit_no = 3'd0;
            ph     = i2cdbw_pkg::PH_ACK;
          end else begin
            bit_no = bit_no + 3'd1;
            ph     = i2cdbw_pkg::PH_BIT;
          end
        end else begin
          ph = ph + 5'd1;
        end
      end else if (ph < i2cdbw_pkg::PH_STOP) begin
        t = ph - i2cdbw_pkg::PH_ACK;
        if (t == 5'd1) rel_q = 1'b1;
        if (t == 5'd2) scl_q = 1'b1;
        // only an address NACK aborts; later NACKs are ignored
        if (t == 5'd3 && byte_no == i2cdbw_pkg::BYTE_ADDR && it.sda_in) begin
          byte_no = i2cdbw_pkg::BYTE_ABORT;
        end
        if (t == 5'd4) scl_q = 1'b0;
        if (t == 5'd5) begin
          rel_q = 1'b0;
          if (byte_no >= i2cdbw_pkg::BYTE_PAY) ph = i2cdbw_pkg::PH_STOP;
          else begin
            byte_no = byte_no + 2'd1;
            ph      = i2cdbw_pkg::PH_BIT;
          end
        end else begin
          ph = ph + 5'd1;
        end
      end else begin
        t = ph - i2cdbw_pkg::PH_STOP;
        if (t == 5'd1) scl_q = 1'b1;
        if (t == 5'd2) sda_q = 1'b1;
        if (t == 5'd3) begin
          done = 1'b1;
          nack = (byte_no == i2cdbw_pkg::BYTE_ABORT);
          ph   = i2cdbw_pkg::PH_IDLE;
        end else begin
          ph = ph + 5'd1;
        end
      end
    end
    r.scl       = scl_q;
    r.sda_out   = rel_q ? 1'b0 : sda_q;
    r.sda_drive = !rel_q;
    r.busy_res  = busy;
    r.done_res  = done;
    r.addr_nack = nack;
    return r;
  endfunction

  task automatic report(string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic got, logic want);
    if (got !== want) report($sformatf("%s got %b expected %b", name, got, want));
  endtask

  always @(posedge clk) begin
    i2cdbw_pkg::out_item_t want;
    if (rst) begin
      ph        = i2cdbw_pkg::PH_IDLE;
      bit_no    = 3'd0;
      byte_no   = i2cdbw_pkg::BYTE_ADDR;
      pay_hold  = 8'h00;
      data_hold = 1'b0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      rel_q     = 1'b0;
      dev_addr  = i2cdbw_pkg::ADDR_RESET;
      levels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) dev_addr = cfg_data;
      // compare before pushing: a result never belongs to this edge's item
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          want = levels_due.pop_front();
          check_field("scl", out_data.scl, want.scl);
          check_field("sda_out", out_data.sda_out, want.sda_out);
          check_field("sda_drive", out_data.sda_drive, want.sda_drive);
          check_field("busy_res", out_data.busy_res, want.busy_res);
          check_field("done_res", out_data.done_res, want.done_res);
          check_field("addr_nack", out_data.addr_nack, want.addr_nack);
        end
      end
      if (in_valid && in_ready) levels_due.push_back(bus_tick(in_data));
    end
    fail_count     <= errors;
    levels_pending <= levels_due.size();
  end

endmodule

FILE: test/tb_i2c_display_byte_writer.sv
// Testbench top for the I2C display byte writer: clock, reset, tick stimulus,
// address writes and the verdict. Depends on i2cdbw_pkg, i2c_display_byte_writer and i2c_tick_checker.
`timescale 1ns / 100ps

module tb_i2c_display_byte_writer;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 322;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  i2cdbw_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  i2cdbw_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  int fail_count;
  int levels_pending;

  // receiver and sender pacing, set by the stimulus process, and the watchdog count
  int rx_stall_pct = 0;
  int hold_ticket  = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int tx_idle_pct  = 0;
  int stuck        = 0;

  always #10 clk = ~clk;

  i2c_display_byte_writer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2c_tick_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .levels_pending (levels_pending)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb_i2c_display_byte_writer NOT OK");
        $finish;
      end
    end
  end

  task automatic send_tick(i2cdbw_pkg::in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender stops and drains every pending result before the write
  task automatic set_address(logic [7:0] addr);
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_pending != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly acknowledged ticks, so most transfers run to the payload byte
  function automatic i2cdbw_pkg::in_item_t random_tick();
    i2cdbw_pkg::in_item_t it;
    it.start_req = ($urandom_range(0, 3) == 0);
    it.is_data   = 1'($urandom_range(0, 1));
    it.payload   = 8'($urandom_range(0, 255));
    it.sda_in    = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  initial begin
    int tx_plan[PHASES];
    int rx_plan[PHASES];
    logic [7:0] addr;
    tx_plan = '{0, 46, 0, 18, 0, 18};
    rx_plan = '{0, 0, 46, 18, 0, 18};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, then a data request at the reset address; busy requests ignored
    send_tick('{start_req: 1'b0, is_data: 1'b1, payload: 8'hFF, sda_in: 1'b1});
    send_tick('{start_req: 1'b0, is_data: 1'b0, payload: 8'h00, sda_in: 1'b0});
    send_tick('{start_req: 1'b1, is_data: 1'b1, payload: 8'hFF, sda_in: 1'b0});
    for (int k = 0; k < 18; k++) begin
      send_tick('{start_req: 1'b1, is_data: k[0], payload: 8'h00, sda_in: k[1]});
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        4:       addr = i2cdbw_pkg::ADDR_RESET;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      set_address(addr);
      tx_idle_pct = tx_plan[p];
      rx_stall_pct <= rx_plan[p];
      // sender keeps offering while the receiver holds off
      if (p == 4) hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_tick(random_tick());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (levels_pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && levels_pending == 0) begin
      $display("tb_i2c_display_byte_writer OK");
    end else begin
      $display("tb_i2c_display_byte_writer NOT OK");
    end
    $finish;
  end

endmodule
